### rtl/ist_pkg.sv
// ist_pkg: shared types, constants and command codes of the interval set tracker
// used by ist_controller, ist_datapath, interval_set_tracker, ist_checker and tb_top
`timescale 1ns / 1ps
`default_nettype none

package ist_pkg;

    localparam int INTERVALS_DEFAULT = 16;
    localparam int VAL_W             = 64;
    localparam int CLS_W             = 8;
    localparam int CNT_OUT_W         = 5;

    // operation codes, the spare code looks a value up like find
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [VAL_W-1:0] value;
        logic [CLS_W-1:0] value_class;
        logic [VAL_W-1:0] stamp;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [VAL_W-1:0]     range_lo;
        logic [VAL_W-1:0]     range_hi;
        logic [CLS_W-1:0]     range_class;
        logic [VAL_W-1:0]     range_stamp;
        logic                 overflow;
        logic [CNT_OUT_W-1:0] interval_count;
    } rsp_t;

    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic [CLS_W-1:0] cls;
        logic [VAL_W-1:0] stamp;
    } entry_t;

    // what the located interval does for the current item
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FIND_HIT,
        ACT_STAMP,
        ACT_MERGE,
        ACT_PRED,
        ACT_SUCC,
        ACT_NEW,
        ACT_OVF_INS,
        ACT_DROP,
        ACT_TRIM_LO,
        ACT_TRIM_HI,
        ACT_SPLIT,
        ACT_OVF_SPLIT
    } act_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN_RD,
        DP_SCAN_END,
        DP_SCAN_CMP,
        DP_WR_MAIN,
        DP_WR_SPLIT,
        DP_CLOSE_INIT,
        DP_CLOSE_RD,
        DP_CLOSE_WR,
        DP_CLOSE_END,
        DP_OPEN_INIT,
        DP_OPEN_RD,
        DP_OPEN_WR,
        DP_OPEN_END,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_WR_MAIN,
        S_WR_SPLIT,
        S_CLOSE_INIT,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_OPEN_INIT,
        S_OPEN_RD,
        S_OPEN_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        dp_op_t op;
        act_t   act;
    } cmd_t;

    typedef struct packed {
        logic       k_eq_used;
        logic       hi_ge;
        logic       close_more;
        logic       open_more;
        logic       holds;
        logic       pred;
        logic       succ;
        logic       full;
        logic       lo_eq;
        logic       hi_eq;
        logic       out_busy;
        logic [1:0] func;
    } status_t;

endpackage

`default_nettype wire

### rtl/ist_stream_if.sv
// ist_stream_if: valid/ready channel carrying one item of a given payload type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ist_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ist_datapath.sv
// ist_datapath: interval table memory, scan and shift registers, result register
// depends on ist_pkg
`timescale 1ns / 1ps
`default_nettype none

module ist_datapath #(
    parameter int MAX_INTERVALS = ist_pkg::INTERVALS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ist_pkg::cmd_t    cmd,
    output ist_pkg::status_t status,
    input  ist_pkg::req_t    req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output ist_pkg::rsp_t    rsp_data
);
    import ist_pkg::*;

    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    entry_t mem [MAX_INTERVALS];

    logic [IW-1:0] rd_addr, wr_addr;
    logic          mem_rd, mem_wr;
    entry_t        wr_data, rd_data_reg;

    req_t          item_reg;
    entry_t        prev_reg, cur_reg;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] used_reg, used_next;
    rsp_t          rsp_reg, rsp_load;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [CW-1:0] main_idx, open_bound, split_idx, k_dec;
    logic [CW:0]   k_plus_wide;
    logic          pos_lt_used, pos_gt0, hi_ge;
    entry_t        new_ent, hi_piece, rep_ent;
    logic          rep_hit;
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    // comparisons on the located interval and its neighbor
    always_comb
    begin
        pos_lt_used = pos_reg < used_reg;
        pos_gt0     = pos_reg != '0;
        hi_ge       = rd_data_reg.hi >= item_reg.value;
        k_plus_wide = {1'b0, k_reg} + 1'b1;
        k_dec       = k_reg - 1'b1;
        split_idx   = pos_reg + 1'b1;
        open_bound  = (cmd.act == ACT_SPLIT) ? split_idx : pos_reg;
        main_idx    = (cmd.act == ACT_MERGE || cmd.act == ACT_PRED) ? pos_reg - 1'b1 : pos_reg;

        status.k_eq_used  = k_reg == used_reg;
        status.hi_ge      = hi_ge;
        status.close_more = k_plus_wide < {1'b0, used_reg};
        status.open_more  = k_reg > open_bound;
        status.holds      = pos_lt_used && (cur_reg.lo <= item_reg.value);
        status.pred       = pos_gt0 && (prev_reg.hi + 1'b1 == item_reg.value)
                            && (prev_reg.cls == item_reg.value_class);
        status.succ       = pos_lt_used && (cur_reg.lo - 1'b1 == item_reg.value)
                            && (cur_reg.cls == item_reg.value_class);
        status.full       = used_reg >= MAX_CNT;
        status.lo_eq      = cur_reg.lo == item_reg.value;
        status.hi_eq      = cur_reg.hi == item_reg.value;
        status.out_busy   = rsp_valid_reg && !rsp_ready;
        status.func       = item_reg.func;
    end

    // entry written at the main index for each action, and the upper piece of a split
    always_comb
    begin
        new_ent = cur_reg;
        case (cmd.act)
            ACT_STAMP:
            begin
                new_ent.stamp = item_reg.stamp;
            end
            ACT_MERGE:
            begin
                new_ent     = prev_reg;
                new_ent.hi  = cur_reg.hi;
                new_ent.stamp = item_reg.stamp;
            end
            ACT_PRED:
            begin
                new_ent       = prev_reg;
                new_ent.hi    = item_reg.value;
                new_ent.stamp = item_reg.stamp;
            end
            ACT_SUCC:
            begin
                new_ent.lo    = item_reg.value;
                new_ent.stamp = item_reg.stamp;
            end
            ACT_NEW:
            begin
                new_ent.lo    = item_reg.value;
                new_ent.hi    = item_reg.value;
                new_ent.cls   = item_reg.value_class;
                new_ent.stamp = item_reg.stamp;
            end
            ACT_TRIM_LO:
            begin
                new_ent.lo = item_reg.value + 1'b1;
            end
            ACT_TRIM_HI, ACT_SPLIT:
            begin
                new_ent.hi = item_reg.value - 1'b1;
            end
            default:
            begin
                new_ent = cur_reg;
            end
        endcase
        hi_piece    = cur_reg;
        hi_piece.lo = item_reg.value + 1'b1;
    end

    // memory port control
    always_comb
    begin
        mem_rd  = 1'b0;
        mem_wr  = 1'b0;
        rd_addr = k_reg[IW-1:0];
        wr_addr = k_reg[IW-1:0];
        wr_data = rd_data_reg;
        case (cmd.op)
            DP_SCAN_RD:
            begin
                mem_rd = 1'b1;
            end
            DP_CLOSE_RD:
            begin
                mem_rd  = 1'b1;
                rd_addr = k_plus_wide[IW-1:0];
            end
            DP_OPEN_RD:
            begin
                mem_rd  = 1'b1;
                rd_addr = k_dec[IW-1:0];
            end
            DP_CLOSE_WR, DP_OPEN_WR:
            begin
                mem_wr = 1'b1;
            end
            DP_WR_MAIN:
            begin
                mem_wr  = 1'b1;
                wr_addr = main_idx[IW-1:0];
                wr_data = new_ent;
            end
            DP_WR_SPLIT:
            begin
                mem_wr  = 1'b1;
                wr_addr = split_idx[IW-1:0];
                wr_data = hi_piece;
            end
            default:
            begin
                mem_rd = 1'b0;
            end
        endcase
    end

    // table storage with registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result of the finished item
    always_comb
    begin
        rep_hit = 1'b0;
        rep_ent = '0;
        case (cmd.act)
            ACT_FIND_HIT, ACT_OVF_SPLIT:
            begin
                rep_hit = 1'b1;
                rep_ent = cur_reg;
            end
            ACT_STAMP, ACT_MERGE, ACT_PRED, ACT_SUCC, ACT_NEW:
            begin
                rep_hit = 1'b1;
                rep_ent = new_ent;
            end
            default:
            begin
                rep_hit = 1'b0;
            end
        endcase
        cnt_ext                 = (CW + CNT_OUT_W)'(used_reg);
        rsp_load.hit            = rep_hit;
        rsp_load.range_lo       = rep_ent.lo;
        rsp_load.range_hi       = rep_ent.hi;
        rsp_load.range_class    = rep_ent.cls;
        rsp_load.range_stamp    = rep_ent.stamp;
        rsp_load.overflow       = (cmd.act == ACT_OVF_INS) || (cmd.act == ACT_OVF_SPLIT);
        rsp_load.interval_count = cnt_ext[CNT_OUT_W-1:0];
    end

    // counters and output valid
    always_comb
    begin
        k_next         = k_reg;
        pos_next       = pos_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (cmd.op)
            DP_LOAD:       k_next = '0;
            DP_SCAN_END:   pos_next = k_reg;
            DP_SCAN_CMP:
            begin
                if (hi_ge)
                begin
                    pos_next = k_reg;
                end
                else
                begin
                    k_next = k_plus_wide[CW-1:0];
                end
            end
            DP_CLOSE_INIT: k_next = pos_reg;
            DP_CLOSE_WR:   k_next = k_plus_wide[CW-1:0];
            DP_CLOSE_END:  used_next = used_reg - 1'b1;
            DP_OPEN_INIT:  k_next = used_reg;
            DP_OPEN_WR:    k_next = k_dec;
            DP_OPEN_END:   used_next = used_reg + 1'b1;
            DP_RESULT:     rsp_valid_next = 1'b1;
            default:       k_next = k_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            pos_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item, neighbor entries and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
        begin
            item_reg <= req_data;
        end
        if (cmd.op == DP_SCAN_CMP)
        begin
            if (hi_ge)
            begin
                cur_reg <= rd_data_reg;
            end
            else
            begin
                prev_reg <= rd_data_reg;
            end
        end
        if (cmd.op == DP_RESULT)
        begin
            rsp_reg <= rsp_load;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= MAX_CNT)
        else $error("interval count above table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |->
            (used_reg == $past(used_reg) + 1'b1) || (used_reg == $past(used_reg) - 1'b1))
        else $error("interval count moved by more than one");

    a_open_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_OPEN_END |-> used_reg < MAX_CNT)
        else $error("slot opened in a full table");

    a_main_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_WR_MAIN |-> main_idx < used_reg)
        else $error("entry written outside the packed table");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_RESULT |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

### rtl/ist_controller.sv
// ist_controller: state machine that sequences scan, update, shift and result
// depends on ist_pkg
`timescale 1ns / 1ps
`default_nettype none

module ist_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  ist_pkg::status_t status,
    output ist_pkg::cmd_t    cmd
);
    import ist_pkg::*;

    state_t state_reg, state_next;
    act_t   act_reg, act_next;
    act_t   decision;

    // action chosen from the located interval
    always_comb
    begin
        case (status.func)
            FUNC_INSERT:
            begin
                if (status.holds)                     decision = ACT_STAMP;
                else if (status.pred && status.succ)  decision = ACT_MERGE;
                else if (status.pred)                 decision = ACT_PRED;
                else if (status.succ)                 decision = ACT_SUCC;
                else if (status.full)                 decision = ACT_OVF_INS;
                else                                  decision = ACT_NEW;
            end
            FUNC_REMOVE:
            begin
                if (!status.holds)                    decision = ACT_NONE;
                else if (status.lo_eq && status.hi_eq) decision = ACT_DROP;
                else if (status.lo_eq)                decision = ACT_TRIM_LO;
                else if (status.hi_eq)                decision = ACT_TRIM_HI;
                else if (status.full)                 decision = ACT_OVF_SPLIT;
                else                                  decision = ACT_SPLIT;
            end
            default:
            begin
                decision = status.holds ? ACT_FIND_HIT : ACT_NONE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_NONE;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        req_ready  = 1'b0;
        cmd.op     = DP_NOP;
        cmd.act    = act_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (status.k_eq_used)
                begin
                    cmd.op     = DP_SCAN_END;
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                cmd.op     = DP_SCAN_CMP;
                state_next = status.hi_ge ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                act_next = decision;
                case (decision)
                    ACT_STAMP, ACT_MERGE, ACT_PRED, ACT_SUCC, ACT_TRIM_LO, ACT_TRIM_HI:
                        state_next = S_WR_MAIN;
                    ACT_DROP:
                        state_next = S_CLOSE_INIT;
                    ACT_NEW, ACT_SPLIT:
                        state_next = S_OPEN_INIT;
                    default:
                        state_next = S_RESULT;
                endcase
            end
            S_WR_MAIN:
            begin
                cmd.op     = DP_WR_MAIN;
                state_next = (act_reg == ACT_MERGE) ? S_CLOSE_INIT : S_RESULT;
            end
            S_WR_SPLIT:
            begin
                cmd.op     = DP_WR_SPLIT;
                state_next = S_WR_MAIN;
            end
            S_CLOSE_INIT:
            begin
                cmd.op     = DP_CLOSE_INIT;
                state_next = S_CLOSE_RD;
            end
            S_CLOSE_RD:
            begin
                if (status.close_more)
                begin
                    cmd.op     = DP_CLOSE_RD;
                    state_next = S_CLOSE_WR;
                end
                else
                begin
                    cmd.op     = DP_CLOSE_END;
                    state_next = S_RESULT;
                end
            end
            S_CLOSE_WR:
            begin
                cmd.op     = DP_CLOSE_WR;
                state_next = S_CLOSE_RD;
            end
            S_OPEN_INIT:
            begin
                cmd.op     = DP_OPEN_INIT;
                state_next = S_OPEN_RD;
            end
            S_OPEN_RD:
            begin
                if (status.open_more)
                begin
                    cmd.op     = DP_OPEN_RD;
                    state_next = S_OPEN_WR;
                end
                else
                begin
                    cmd.op     = DP_OPEN_END;
                    state_next = (act_reg == ACT_SPLIT) ? S_WR_SPLIT : S_WR_MAIN;
                end
            end
            S_OPEN_WR:
            begin
                cmd.op     = DP_OPEN_WR;
                state_next = S_OPEN_RD;
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !status.out_busy) |=> state_reg == S_IDLE)
        else $error("free result slot did not finish the item");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && (decision == ACT_OVF_INS || decision == ACT_OVF_SPLIT))
            |-> status.full)
        else $error("overflow taken with room in the table");

    a_remove_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && (decision == ACT_DROP || decision == ACT_TRIM_LO ||
            decision == ACT_TRIM_HI || decision == ACT_SPLIT)) |-> status.holds)
        else $error("remove changed an interval that does not hold the value");

endmodule

`default_nettype wire

### rtl/interval_set_tracker.sv
// interval_set_tracker: an item goes from acceptance to a valid result through a scan of the
// table entries (up to the interval count, with an end step when the scan passes the last entry),
// zero to two table writes, the opening or closing of a slot with the entries that it moves, and
// any wait while the previous result is still held. The next item is taken in the idle state
// entered when the result is loaded, while that result waits in its output register. Reset
// (rst_n low, asynchronous) empties the table.
`timescale 1ns / 1ps
`default_nettype none

module interval_set_tracker #(
    parameter int MAX_INTERVALS = ist_pkg::INTERVALS_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    ist_stream_if.sink   req,
    ist_stream_if.source rsp
);
    import ist_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    req_ready;

    // sequencing
    ist_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // table and result
    ist_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

### test/ist_checker.sv
// ist_checker: watches the request and response channels of interval_set_tracker,
// keeps its own copy of the interval table and compares every response item
// depends on ist_pkg and ist_stream_if
`timescale 1ns / 1ps

module ist_checker #(
    parameter int MAX_INTERVALS = ist_pkg::INTERVALS_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    ist_stream_if req,
    ist_stream_if rsp,
    output int    fail_count,
    output int    pending
);
    import ist_pkg::*;

    // shadow interval table, sorted and packed in 0 .. held-1
    logic [VAL_W-1:0] tab_lo    [MAX_INTERVALS];
    logic [VAL_W-1:0] tab_hi    [MAX_INTERVALS];
    logic [CLS_W-1:0] tab_cls   [MAX_INTERVALS];
    logic [VAL_W-1:0] tab_stamp [MAX_INTERVALS];
    int               held;

    rsp_t expected_rsps[$];

    assign pending = expected_rsps.size();

    task automatic make_room(input int p);
        for (int j = held; j > p; j--)
        begin
            tab_lo[j]    = tab_lo[j-1];
            tab_hi[j]    = tab_hi[j-1];
            tab_cls[j]   = tab_cls[j-1];
            tab_stamp[j] = tab_stamp[j-1];
        end
        held++;
    endtask

    task automatic squeeze_out(input int p);
        for (int j = p; j + 1 < held; j++)
        begin
            tab_lo[j]    = tab_lo[j+1];
            tab_hi[j]    = tab_hi[j+1];
            tab_cls[j]   = tab_cls[j+1];
            tab_stamp[j] = tab_stamp[j+1];
        end
        held--;
    endtask

    // apply one request to the shadow table and return its response
    task automatic apply_request(input req_t r, output rsp_t e);
        int   k;
        logic holds, report, ovf, pred, succ;
        int   rep;
        k      = 0;
        report = 1'b0;
        ovf    = 1'b0;
        rep    = 0;
        while (k < held && tab_hi[k] < r.value)
            k++;
        holds = (k < held) && (tab_lo[k] <= r.value);
        if (r.func == FUNC_INSERT)
        begin
            if (holds)
            begin
                tab_stamp[k] = r.stamp;
                report = 1'b1;
                rep = k;
            end
            else
            begin
                pred = k > 0 && tab_hi[k-1] + 64'd1 == r.value
                       && tab_cls[k-1] == r.value_class;
                succ = k < held && tab_lo[k] - 64'd1 == r.value
                       && tab_cls[k] == r.value_class;
                if (pred && succ)
                begin
                    tab_hi[k-1]    = tab_hi[k];
                    tab_stamp[k-1] = r.stamp;
                    squeeze_out(k);
                    report = 1'b1;
                    rep = k - 1;
                end
                else if (pred)
                begin
                    tab_hi[k-1]    = r.value;
                    tab_stamp[k-1] = r.stamp;
                    report = 1'b1;
                    rep = k - 1;
                end
                else if (succ)
                begin
                    tab_lo[k]    = r.value;
                    tab_stamp[k] = r.stamp;
                    report = 1'b1;
                    rep = k;
                end
                else if (held >= MAX_INTERVALS)
                    ovf = 1'b1;
                else
                begin
                    make_room(k);
                    tab_lo[k]    = r.value;
                    tab_hi[k]    = r.value;
                    tab_cls[k]   = r.value_class;
                    tab_stamp[k] = r.stamp;
                    report = 1'b1;
                    rep = k;
                end
            end
        end
        else if (r.func == FUNC_REMOVE)
        begin
            if (holds)
            begin
                if (tab_lo[k] == r.value && tab_hi[k] == r.value)
                    squeeze_out(k);
                else if (tab_lo[k] == r.value)
                    tab_lo[k] = r.value + 64'd1;
                else if (tab_hi[k] == r.value)
                    tab_hi[k] = r.value - 64'd1;
                else if (held >= MAX_INTERVALS)
                begin
                    ovf = 1'b1;
                    report = 1'b1;
                    rep = k;
                end
                else
                begin
                    // split: both pieces keep class and stamp
                    make_room(k);
                    tab_hi[k]   = r.value - 64'd1;
                    tab_lo[k+1] = r.value + 64'd1;
                end
            end
        end
        else if (holds)
        begin
            report = 1'b1;
            rep = k;
        end
        e = '0;
        if (report)
        begin
            e.hit         = 1'b1;
            e.range_lo    = tab_lo[rep];
            e.range_hi    = tab_hi[rep];
            e.range_class = tab_cls[rep];
            e.range_stamp = tab_stamp[rep];
        end
        e.overflow       = ovf;
        e.interval_count = held[CNT_OUT_W-1:0];
    endtask

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    // predict on accepted requests, compare on accepted responses
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        rsp_t a;
        if (!rst_n)
        begin
            held = 0;
            expected_rsps.delete();
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                apply_request(req.data, e);
                expected_rsps.push_back(e);
            end
            if (rsp.valid && rsp.ready)
            begin
                a = rsp.data;
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: response item with none expected, actual %h", $time, a);
                    fail_count++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    check_field("hit", e.hit, a.hit);
                    check_field("range_lo", e.range_lo, a.range_lo);
                    check_field("range_hi", e.range_hi, a.range_hi);
                    check_field("range_class", e.range_class, a.range_class);
                    check_field("range_stamp", e.range_stamp, a.range_stamp);
                    check_field("overflow", e.overflow, a.overflow);
                    check_field("interval_count", e.interval_count, a.interval_count);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

### test/tb_top.sv
// tb_top: drives directed and random insert/remove/find items into interval_set_tracker
// under several idle/stall mixes; checking is done by ist_checker
// depends on ist_pkg, ist_stream_if, ist_checker and the block itself
`timescale 1ns / 1ps

module tb_top;
    import ist_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 350;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;
    logic [VAL_W-1:0] window_base;

    ist_stream_if #(.payload_t(req_t)) req_ch ();
    ist_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    interval_set_tracker DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ist_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
    begin
        if (rst_n)
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no accepted item on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("interval_set_tracker: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // present one item, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] f, input logic [63:0] v,
                             input logic [7:0] c, input logic [63:0] s);
        req_t r;
        r.func        = f;
        r.value       = v;
        r.value_class = c;
        r.stamp       = s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // random item clustered around a moving window so intervals form and join
    task automatic random_item();
        logic [1:0]  f;
        logic [63:0] v;
        logic [7:0]  c;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 45)
            f = FUNC_INSERT;
        else if (pick < 80)
            f = FUNC_REMOVE;
        else
            f = ($urandom_range(1) == 0) ? FUNC_FIND : FUNC_SPARE;
        if ($urandom_range(99) < 3)
            v = rand64();
        else
            v = window_base + 64'($urandom_range(40));
        c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        send_item(f, v, c, rand64());
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            if (n % 70 == 0)
            begin
                case ($urandom_range(3))
                    0: window_base = 64'd0;
                    1: window_base = 64'hFFFF_FFFF_FFFF_FFE0;
                    default: window_base = rand64();
                endcase
            end
            random_item();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        window_base    = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, joins, class boundaries, splits, overflow
        send_item(FUNC_FIND, 64'd0, 8'd0, 64'd0);
        send_item(FUNC_INSERT, 64'd0, 8'd0, 64'd0);
        send_item(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF, 64'h5);
        send_item(FUNC_INSERT, 64'd2, 8'd0, 64'd2);
        send_item(FUNC_INSERT, 64'd1, 8'd0, 64'd7);
        send_item(FUNC_INSERT, 64'd3, 8'd9, 64'd3);
        send_item(FUNC_INSERT, 64'd1, 8'd5, 64'd11);
        send_item(FUNC_SPARE, 64'd2, 8'd0, 64'd0);
        send_item(FUNC_REMOVE, 64'd1, 8'd0, 64'd0);
        send_item(FUNC_REMOVE, 64'd1, 8'd0, 64'd0);
        send_item(FUNC_INSERT, 64'd1, 8'd0, 64'd12);
        send_item(FUNC_REMOVE, 64'd0, 8'd0, 64'd0);
        send_item(FUNC_REMOVE, 64'd2, 8'd0, 64'd0);
        send_item(FUNC_REMOVE, 64'd3, 8'd0, 64'd0);
        send_item(FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 64'd0);
        send_item(FUNC_FIND, 64'h8000_0000_0000_0000, 8'd0, 64'd0);
        // fill the table with separated values, then overflow on insert and split
        for (int j = 0; j < 14; j++)
            send_item(FUNC_INSERT, 64'd100 + 64'(3 * j), 8'(j), 64'(j));
        send_item(FUNC_INSERT, 64'd500, 8'd1, 64'd1);
        send_item(FUNC_INSERT, 64'd101, 8'd0, 64'd9);
        send_item(FUNC_INSERT, 64'd102, 8'd0, 64'd10);
        send_item(FUNC_REMOVE, 64'd101, 8'd0, 64'd0);

        run_phase(0, 0);
        run_phase(61, 0);
        run_phase(0, 61);
        run_phase(32, 32);

        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("interval_set_tracker: match");
        else
            $display("interval_set_tracker: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/ist_pkg.sv
rtl/ist_stream_if.sv
rtl/ist_datapath.sv
rtl/ist_controller.sv
rtl/interval_set_tracker.sv
test/ist_checker.sv
test/tb_top.sv
